@@ src/set_assoc_cache_lru_lookup_macros.svh @@
// assertion macros for the set-associative lru lookup block
// expects clk and arst_n in the scope of the including module
`ifndef SET_ASSOC_CACHE_LRU_LOOKUP_MACROS_SVH
`define SET_ASSOC_CACHE_LRU_LOOKUP_MACROS_SVH

// same-cycle implication, checked outside reset
`define SALRU_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define SALRU_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/salru_pkg.sv @@
// shared types and constants for the set-associative lru lookup block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package salru_pkg;

	// default geometry
	localparam int SETS_DEF        = 64;
	localparam int WAYS_DEF        = 4;
	localparam int OFFSET_BITS_DEF = 4;
	localparam int ADDR_BITS_DEF   = 32;

	// fixed field widths
	localparam int ADDR_W    = 32;
	localparam int WAY_OUT_W = 2;
	localparam int CNT_W     = 32;

	// front-to-back queue
	localparam int QUEUE_DEPTH = 2;
	localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);

	// request type code
	localparam logic REQ_FLUSH = 1'b1;

	// back-end sequencer states
	typedef enum logic [2:0] {
		BK_INIT,
		BK_IDLE,
		BK_UPDATE,
		BK_FLUSH,
		BK_FL_RESP
	} back_state_t;

	// head of queue as seen by the back end
	typedef struct packed {
		logic vld;
		logic flush;
	} q_head_t;

	// back-end status returned to the front end
	typedef struct packed {
		logic pop;
		logic init_busy;
	} back_stat_t;

endpackage

`default_nettype wire

@@ src/set_assoc_cache_lru_lookup.sv @@
// set-associative tag lookup with age-counter lru; front queue feeds a back-end sequencer
// an accepted access is queued; the back end pops it and reads its set row into registers,
// then compares and writes back once the result register is free; one access at a time
// a flush sweeps the valid memory one set a cycle, then returns a result
// reset: tags, ages and valid bits initialised set by set, in_ready low meanwhile
`timescale 1ns / 1ps
`default_nettype none

`include "set_assoc_cache_lru_lookup_macros.svh"

module set_assoc_cache_lru_lookup #(
	parameter int SETS        = salru_pkg::SETS_DEF,
	parameter int WAYS        = salru_pkg::WAYS_DEF,
	parameter int OFFSET_BITS = salru_pkg::OFFSET_BITS_DEF,
	parameter int ADDR_BITS   = salru_pkg::ADDR_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            req_type,
	input  logic [salru_pkg::ADDR_W-1:0]    addr,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            hit,
	output logic [salru_pkg::WAY_OUT_W-1:0] way,
	output logic [salru_pkg::CNT_W-1:0]     miss_count,
	output logic [salru_pkg::CNT_W-1:0]     access_count
);
	import salru_pkg::*;

	localparam int IDX_W   = $clog2(SETS);
	localparam int SET_W   = (IDX_W > 0) ? IDX_W : 1;
	localparam int EFF_A   = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
	localparam int TAG_RAW = EFF_A - OFFSET_BITS - IDX_W;
	localparam int TAG_W   = (TAG_RAW > 0) ? TAG_RAW : 1;

	q_head_t          q_head;
	logic [SET_W-1:0] q_set;
	logic [TAG_W-1:0] q_tag;
	back_stat_t       bk_stat;

	// transaction intake and queue
	salru_front #(
		.SETS        (SETS),
		.OFFSET_BITS (OFFSET_BITS),
		.ADDR_BITS   (ADDR_BITS),
		.SET_W       (SET_W),
		.TAG_W       (TAG_W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.req_type (req_type),
		.addr     (addr),
		.q_head   (q_head),
		.q_set    (q_set),
		.q_tag    (q_tag),
		.bk_stat  (bk_stat)
	);

	// lookup, replacement and result
	salru_back #(
		.SETS  (SETS),
		.WAYS  (WAYS),
		.SET_W (SET_W),
		.TAG_W (TAG_W)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_head       (q_head),
		.q_set        (q_set),
		.q_tag        (q_tag),
		.bk_stat      (bk_stat),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.hit          (hit),
		.way          (way),
		.miss_count   (miss_count),
		.access_count (access_count)
	);

	// checks
	`SALRU_ASSERT_IMP(a_no_intake_during_clear, bk_stat.init_busy, !in_ready, "intake during clear")
	`SALRU_ASSERT_IMP(a_pop_needs_entry, bk_stat.pop, q_head.vld, "pop from empty queue")
	`SALRU_ASSERT_NXT(a_no_back_to_back_pop, bk_stat.pop, !bk_stat.pop, "back end popped twice")

endmodule

`default_nettype wire

@@ src/salru_front.sv @@
// front end: accepts transactions, splits the address into set and tag, queues them
// depends on salru_pkg
`timescale 1ns / 1ps
`default_nettype none

module salru_front #(
	parameter int SETS        = salru_pkg::SETS_DEF,
	parameter int OFFSET_BITS = salru_pkg::OFFSET_BITS_DEF,
	parameter int ADDR_BITS   = salru_pkg::ADDR_BITS_DEF,
	parameter int SET_W       = 6,
	parameter int TAG_W       = 22
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          req_type,
	input  logic [salru_pkg::ADDR_W-1:0]  addr,
	output salru_pkg::q_head_t            q_head,
	output logic [SET_W-1:0]              q_set,
	output logic [TAG_W-1:0]              q_tag,
	input  salru_pkg::back_stat_t         bk_stat
);
	import salru_pkg::*;

	localparam int IDX_W  = $clog2(SETS);
	localparam int EFF_A  = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
	localparam int TAG_SH = OFFSET_BITS + IDX_W;
	localparam logic [ADDR_W-1:0] AMASK =
		(EFF_A >= ADDR_W) ? {ADDR_W{1'b1}} : ADDR_W'((64'd1 << EFF_A) - 64'd1);
	localparam logic [SET_W:0] SETS_V = (SET_W + 1)'(SETS);
	localparam logic [Q_PTR_W:0] Q_FULL = (Q_PTR_W + 1)'(QUEUE_DEPTH);

	logic [ADDR_W-1:0] addr_m;
	logic [ADDR_W-1:0] set_sh;
	logic [ADDR_W-1:0] tag_sh;
	logic [SET_W:0]    set_raw;
	logic [SET_W-1:0]  set_idx;
	logic [TAG_W-1:0]  tag_val;

	logic              qf_q [QUEUE_DEPTH];
	logic [SET_W-1:0]  qs_q [QUEUE_DEPTH];
	logic [TAG_W-1:0]  qt_q [QUEUE_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_PTR_W:0]   cnt_q;
	logic               push;

	// address split, set index folded into range for set counts that are not a power of two
	always_comb begin
		addr_m  = addr & AMASK;
		set_sh  = addr_m >> OFFSET_BITS;
		tag_sh  = addr_m >> TAG_SH;
		set_raw = '0;
		if (IDX_W > 0) begin
			set_raw = {1'b0, set_sh[SET_W-1:0]};
		end
		if (set_raw >= SETS_V) begin
			set_idx = SET_W'(set_raw - SETS_V);
		end else begin
			set_idx = set_raw[SET_W-1:0];
		end
		tag_val = tag_sh[TAG_W-1:0];
	end

	// input handshake, held off while the back end clears its memories
	assign in_ready = (cnt_q != Q_FULL) && !bk_stat.init_busy;
	assign push     = in_valid && in_ready;

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			qf_q[wr_ptr_q] <= (req_type == REQ_FLUSH);
			qs_q[wr_ptr_q] <= set_idx;
			qt_q[wr_ptr_q] <= tag_val;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (bk_stat.pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, bk_stat.pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// queue head
	assign q_head.vld   = (cnt_q != '0);
	assign q_head.flush = qf_q[rd_ptr_q];
	assign q_set        = qs_q[rd_ptr_q];
	assign q_tag        = qt_q[rd_ptr_q];

endmodule

`default_nettype wire

@@ src/salru_back.sv @@
// back end: tag, age and valid memories, lookup, lru update, counters, result register
// depends on salru_pkg
`timescale 1ns / 1ps
`default_nettype none

module salru_back #(
	parameter int SETS  = salru_pkg::SETS_DEF,
	parameter int WAYS  = salru_pkg::WAYS_DEF,
	parameter int SET_W = 6,
	parameter int TAG_W = 22
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  salru_pkg::q_head_t              q_head,
	input  logic [SET_W-1:0]                q_set,
	input  logic [TAG_W-1:0]                q_tag,
	output salru_pkg::back_stat_t           bk_stat,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            hit,
	output logic [salru_pkg::WAY_OUT_W-1:0] way,
	output logic [salru_pkg::CNT_W-1:0]     miss_count,
	output logic [salru_pkg::CNT_W-1:0]     access_count
);
	import salru_pkg::*;

	localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam logic [WAY_W-1:0] AGE_MAX  = WAY_W'(WAYS - 1);
	localparam logic [SET_W-1:0] LAST_SET = SET_W'(SETS - 1);

	typedef logic [WAYS-1:0][TAG_W-1:0] tag_row_t;
	typedef logic [WAYS-1:0][WAY_W-1:0] age_row_t;

	// memories, one row per set
	tag_row_t        tag_mem [SETS];
	age_row_t        age_mem [SETS];
	logic [WAYS-1:0] vld_mem [SETS];

	back_state_t state_q;
	back_state_t nxt_state;
	logic [SET_W-1:0] sweep_q;
	logic             sweep_last;

	tag_row_t         rd_tag_s1;
	age_row_t         rd_age_s1;
	logic [WAYS-1:0]  rd_vld_s1;
	logic [SET_W-1:0] cur_set_s1;
	logic [TAG_W-1:0] cur_tag_s1;

	logic [CNT_W-1:0] miss_q;
	logic [CNT_W-1:0] acc_q;
	logic             out_vld_q;
	logic             hit_q;
	logic [WAY_OUT_W-1:0] way_q;
	logic [CNT_W-1:0] miss_out_q;
	logic [CNT_W-1:0] acc_out_q;
	logic             out_free;

	// sequencer controls
	logic             pop;
	logic             rd_en;
	logic             we_tag;
	logic             we_age;
	logic             we_vld;
	logic [SET_W-1:0] wr_addr;
	tag_row_t         wr_tag;
	age_row_t         wr_age;
	logic [WAYS-1:0]  wr_vld;
	logic             ld_acc;
	logic             ld_fl;

	// lookup datapath
	logic             found;
	logic [WAY_W-1:0] m_idx;
	logic [WAY_W-1:0] victim;
	logic [WAY_W-1:0] sel;
	logic             hit_c;
	logic [WAY_W-1:0] own;
	age_row_t         new_age;
	tag_row_t         new_tag;
	logic [WAYS-1:0]  new_vld;
	age_row_t         age_rst;

	assign out_free   = !out_vld_q || out_ready;
	assign sweep_last = (sweep_q == LAST_SET);

	// reset ages: each way starts at its own index
	always_comb begin
		for (int i = 0; i < WAYS; i++) begin
			age_rst[i] = WAY_W'(i);
		end
	end

	// tag compare, victim pick and age update
	always_comb begin
		found  = 1'b0;
		m_idx  = '0;
		victim = '0;
		for (int i = WAYS - 1; i >= 0; i--) begin
			if (rd_tag_s1[i] == cur_tag_s1) begin
				found = 1'b1;
				m_idx = WAY_W'(i);
			end
		end
		for (int i = 0; i < WAYS; i++) begin
			if (rd_age_s1[i] == AGE_MAX) begin
				victim = WAY_W'(i);
			end
		end
		sel   = found ? m_idx : victim;
		hit_c = found && rd_vld_s1[m_idx];
		own   = rd_age_s1[sel];
		for (int i = 0; i < WAYS; i++) begin
			if (WAY_W'(i) == sel) begin
				new_age[i] = '0;
			end else if (rd_age_s1[i] < own) begin
				new_age[i] = rd_age_s1[i] + 1'b1;
			end else begin
				new_age[i] = rd_age_s1[i];
			end
		end
		new_tag      = rd_tag_s1;
		new_tag[sel] = cur_tag_s1;
		new_vld      = rd_vld_s1;
		new_vld[sel] = 1'b1;
	end

	// next state
	always_comb begin
		nxt_state = state_q;
		case (state_q)
			BK_INIT: begin
				if (sweep_last) nxt_state = BK_IDLE;
			end
			BK_IDLE: begin
				if (q_head.vld) nxt_state = q_head.flush ? BK_FLUSH : BK_UPDATE;
			end
			BK_UPDATE: begin
				if (out_free) nxt_state = BK_IDLE;
			end
			BK_FLUSH: begin
				if (sweep_last) nxt_state = BK_FL_RESP;
			end
			BK_FL_RESP: begin
				if (out_free) nxt_state = BK_IDLE;
			end
			default: nxt_state = BK_INIT;
		endcase
	end

	// sequencer outputs
	always_comb begin
		pop     = 1'b0;
		rd_en   = 1'b0;
		we_tag  = 1'b0;
		we_age  = 1'b0;
		we_vld  = 1'b0;
		wr_addr = sweep_q;
		wr_tag  = '0;
		wr_age  = age_rst;
		wr_vld  = '0;
		ld_acc  = 1'b0;
		ld_fl   = 1'b0;
		case (state_q)
			BK_INIT: begin
				we_tag = 1'b1;
				we_age = 1'b1;
				we_vld = 1'b1;
			end
			BK_IDLE: begin
				pop   = q_head.vld;
				rd_en = q_head.vld && !q_head.flush;
			end
			BK_UPDATE: begin
				we_tag  = out_free;
				we_age  = out_free;
				we_vld  = out_free;
				wr_addr = cur_set_s1;
				wr_tag  = new_tag;
				wr_age  = new_age;
				wr_vld  = new_vld;
				ld_acc  = out_free;
			end
			BK_FLUSH: begin
				we_vld = 1'b1;
			end
			BK_FL_RESP: begin
				ld_fl = out_free;
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	// memory write and registered read
	always_ff @(posedge clk) begin
		if (we_tag) tag_mem[wr_addr] <= wr_tag;
		if (we_age) age_mem[wr_addr] <= wr_age;
		if (we_vld) vld_mem[wr_addr] <= wr_vld;
		if (rd_en) begin
			rd_tag_s1 <= tag_mem[q_set];
			rd_age_s1 <= age_mem[q_set];
			rd_vld_s1 <= vld_mem[q_set];
		end
	end

	// transaction capture and result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_set_s1 <= q_set;
			cur_tag_s1 <= q_tag;
		end
		if (ld_acc) begin
			hit_q      <= hit_c;
			way_q      <= WAY_OUT_W'(sel);
			miss_out_q <= miss_q + CNT_W'(!hit_c);
			acc_out_q  <= acc_q + 1'b1;
		end else if (ld_fl) begin
			hit_q      <= 1'b0;
			way_q      <= '0;
			miss_out_q <= miss_q;
			acc_out_q  <= acc_q + 1'b1;
		end
	end

	// state, sweep counter, running counters, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_INIT;
			sweep_q   <= '0;
			miss_q    <= '0;
			acc_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= nxt_state;
			if (state_q == BK_INIT || state_q == BK_FLUSH) begin
				sweep_q <= sweep_last ? '0 : sweep_q + 1'b1;
			end
			if (ld_acc) begin
				acc_q <= acc_q + 1'b1;
				if (!hit_c) miss_q <= miss_q + 1'b1;
			end else if (ld_fl) begin
				acc_q <= acc_q + 1'b1;
			end
			if (ld_acc || ld_fl) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign bk_stat.pop       = pop;
	assign bk_stat.init_busy = (state_q == BK_INIT);

	assign out_valid    = out_vld_q;
	assign hit          = hit_q;
	assign way          = way_q;
	assign miss_count   = miss_out_q;
	assign access_count = acc_out_q;

endmodule

`default_nettype wire
